/* hdl/nne_pkg.sv */
// Shared types, constants and the sigmoid table builder of the NEAT network evaluator.
`default_nettype none

package nne_pkg;

   localparam int MAX_NEURONS     = 64;
   localparam int NEURON_AW       = $clog2(MAX_NEURONS);
   localparam int NCNT_W          = NEURON_AW + 1;
   localparam int MAX_LINKS       = 256;
   localparam int LINK_AW         = $clog2(MAX_LINKS);
   localparam int FRAC_BITS       = 12;
   localparam int SIGMOID_ENTRIES = 1024;
   localparam int SIG_AW          = $clog2(SIGMOID_ENTRIES);
   localparam int X_W             = FRAC_BITS + 4;
   localparam int ACT_W           = 16;
   localparam int OUT_W           = FRAC_BITS + 1;
   localparam int RESP_W          = 15;
   localparam int LCNT_W          = 8;
   localparam int SRC_W           = 6;
   localparam int PROD_W          = 2 * ACT_W;
   localparam int ACC_W           = PROD_W + LCNT_W;
   localparam int MAX_RESULTS     = 64;
   localparam int RCNT_W          = 7;
   localparam int ORD_W           = 6;
   localparam int CFG_W           = 7;
   localparam int ONE             = 1 << FRAC_BITS;

   // Reciprocal of three; floor(x / 3) is (x * RECIP_THIRD) >> 33 for any 32-bit x.
   localparam logic [63:0] RECIP_THIRD = 64'hAAAA_AAAB;

   localparam logic [1:0] KIND_NEURON = 2'd0;
   localparam logic [1:0] KIND_LINK   = 2'd1;
   localparam logic [1:0] KIND_INPUT  = 2'd2;

   localparam logic [1:0] NTYPE_INPUT  = 2'd0;
   localparam logic [1:0] NTYPE_OUTPUT = 2'd3;

   localparam logic [1:0] CSR_FLUSH_DEPTH  = 2'd0;
   localparam logic [1:0] CSR_NEURON_COUNT = 2'd1;

   typedef struct packed {
      logic signed [ACT_W-1:0]  act;
      logic [1:0]               ntype;
      logic [RESP_W-1:0]        resp;
      logic [LCNT_W-1:0]        start;
      logic [LCNT_W-1:0]        len;
   } node_word_type;

   typedef struct packed {
      logic [SRC_W-1:0]         src;
      logic signed [ACT_W-1:0]  weight;
   } link_word_type;

   typedef struct packed {
      logic                     start;
      logic                     neg;
      logic [ACC_W-1:0]         mag;
      logic [RESP_W-1:0]        resp;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [X_W-1:0]    x;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MERGE,
      ST_PASS,
      ST_SCAN,
      ST_SCAN_CHK,
      ST_NODE,
      ST_INFO,
      ST_LINK,
      ST_SRC,
      ST_MUL,
      ST_ACC,
      ST_DIV,
      ST_DIVW,
      ST_WB,
      ST_PASS_END,
      ST_FLUSH
   } state_type;

   typedef logic [OUT_W-1:0] sig_table_type [SIGMOID_ENTRIES];

   // exp(-t) in Q31 from a short series at t/256, squared eight times.
   function automatic logic [63:0] exp_neg_q31(logic [63:0] t);
      logic [63:0] v;
      logic [63:0] v2;
      logic [63:0] v3;
      logic [63:0] v4;
      logic [63:0] r;
      v  = (t << (31 - FRAC_BITS)) >> 8;
      v2 = (v * v) >> 31;
      v3 = (v2 * v) >> 31;
      v4 = (v2 * v2) >> 31;
      r  = (64'd1 << 31) - v + (v2 >> 1) - ((v3 * RECIP_THIRD) >> 34)
           + ((v4 * RECIP_THIRD) >> 36);
      for (int i = 0; i < 8; i++) begin
         r = (r * r + (64'd1 << 30)) >> 31;
      end
      return r;
   endfunction

   function automatic logic [63:0] sig_pos(logic [63:0] t);
      logic [63:0] d;
      logic [63:0] rem;
      logic [63:0] quo;
      d   = (64'd1 << 31) + exp_neg_q31(t);
      rem = (64'(ONE) << 31) + (d >> 1);
      quo = '0;
      // The quotient never exceeds ONE, so OUT_W shift-subtract steps are enough.
      for (int i = OUT_W - 1; i >= 0; i--) begin
         if (rem >= (d << i)) begin
            rem    = rem - (d << i);
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Entry k holds the sigmoid at the midpoint of its interval over [-8, 8).
   function automatic sig_table_type build_sig_table();
      sig_table_type tab;
      longint span;
      longint half;
      longint x;
      span = longint'(16) << FRAC_BITS;
      half = longint'(8) << FRAC_BITS;
      for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
         x = (((2 * longint'(k) + 1) * span) >> (SIG_AW + 1)) - half;
         if (x >= 0) begin
            tab[k] = OUT_W'(sig_pos(64'(x)));
         end else begin
            tab[k] = OUT_W'(64'(ONE) - sig_pos(64'(-x)));
         end
      end
      return tab;
   endfunction

endpackage

`default_nettype wire

/* hdl/nne_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module nne_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/nne_sigmoid_rom.sv */
// Sigmoid lookup ROM over [-8, 8) with registered read data.
`default_nettype none

module nne_sigmoid_rom (
   input  logic                           clock,
   input  logic [nne_pkg::SIG_AW-1:0]     addr,
   output logic [nne_pkg::OUT_W-1:0]      data
);

   localparam nne_pkg::sig_table_type SIG_TABLE = nne_pkg::build_sig_table();

   logic [nne_pkg::OUT_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      data_ff <= SIG_TABLE[addr];
   end

   assign data = data_ff;

endmodule

`default_nettype wire

/* hdl/nne_divider.sv */
// Iterative restoring divider: saturated Q4.12 net input from the link sum and response.
`default_nettype none

module nne_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  nne_pkg::div_req_type  div_req,
   output nne_pkg::div_rsp_type  div_rsp
);

   localparam int STEP_W = $clog2(nne_pkg::X_W + 1);
   localparam logic [nne_pkg::X_W-1:0] LIM = nne_pkg::X_W'(1) << (nne_pkg::X_W - 1);

   logic                          running_ff, running_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic [nne_pkg::RESP_W-1:0]    rem_ff, rem_in;
   logic [nne_pkg::X_W-1:0]       low_ff, low_in;
   logic [nne_pkg::X_W-1:0]       quo_ff, quo_in;
   logic [nne_pkg::RESP_W-1:0]    resp_ff, resp_in;
   logic                          neg_ff, neg_in;
   logic                          sat_ff, sat_in;

   logic [nne_pkg::RESP_W-1:0]    resp_eff;
   logic                          big;
   logic [nne_pkg::RESP_W:0]      trial;
   logic [nne_pkg::RESP_W:0]      diff;
   logic                          fits;
   logic [nne_pkg::X_W-1:0]       magc;
   logic [nne_pkg::X_W-1:0]       x_val;

   always_comb begin
      resp_eff = (div_req.resp == '0) ? nne_pkg::RESP_W'(1) : div_req.resp;
      // A quotient of 2^X_W or more always saturates, so only X_W bits are developed.
      big = div_req.mag >= nne_pkg::ACC_W'({resp_eff, {nne_pkg::X_W{1'b0}}});
      trial = {rem_ff, low_ff[nne_pkg::X_W-1]};
      fits  = trial >= {1'b0, resp_ff};
      diff  = trial - {1'b0, resp_ff};

      running_in = running_ff;
      step_in    = step_ff;
      rem_in     = rem_ff;
      low_in     = low_ff;
      quo_in     = quo_ff;
      resp_in    = resp_ff;
      neg_in     = neg_ff;
      sat_in     = sat_ff;

      if (div_req.start) begin
         running_in = 1'b1;
         step_in    = STEP_W'(nne_pkg::X_W);
         rem_in     = big ? '0 : div_req.mag[nne_pkg::X_W +: nne_pkg::RESP_W];
         low_in     = div_req.mag[nne_pkg::X_W-1:0];
         quo_in     = '0;
         resp_in    = resp_eff;
         neg_in     = div_req.neg;
         sat_in     = big;
      end else if (running_ff) begin
         rem_in  = fits ? diff[nne_pkg::RESP_W-1:0] : trial[nne_pkg::RESP_W-1:0];
         low_in  = {low_ff[nne_pkg::X_W-2:0], 1'b0};
         quo_in  = {quo_ff[nne_pkg::X_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            running_in = 1'b0;
         end
      end

      magc = (sat_ff || quo_ff > LIM) ? LIM : quo_ff;
      if (neg_ff) begin
         x_val = nne_pkg::X_W'(0) - magc;
      end else begin
         x_val = (magc >= LIM) ? LIM - nne_pkg::X_W'(1) : magc;
      end
      div_rsp.done = !running_ff;
      div_rsp.x    = x_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
      end else begin
         running_ff <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quo_ff  <= quo_in;
      resp_ff <= resp_in;
      neg_ff  <= neg_in;
      sat_ff  <= sat_in;
   end

endmodule

`default_nettype wire

/* hdl/neat_network_evaluator.sv */
// Top level of the NEAT network evaluator: tables in RAM, evaluation sequencer and outputs.
//
//   channel  direction  handshake         payload
//   req      in         req_valid/stall   kind, indices, neuron and link entry, input value
//   rsp      out        rsp_valid/stall   out_value, out_ordinal, out_last
//   csr      in         csr_valid/ready   csr_index, csr_wdata (flush_depth, neuron_count)
//
// A link load is written straight from idle; a neuron load or a plain input value goes
// through a merge state (read-modify-write of the shared neuron RAM). An evaluation walks
// one neuron RAM port and one link RAM port link by link; the divider develops 16 quotient
// bits per neuron. Reset sets the flush depth to 1 and clears the neuron count, the
// activation valid bits and the pending and output valid bits. A stalled result holds the
// sequencer when another output is ready behind it, and also in the final flush.
`default_nettype none

module neat_network_evaluator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_kind,
   input  logic [5:0]                       req_neuron_index,
   input  logic [1:0]                       req_neuron_type,
   input  logic [nne_pkg::RESP_W-1:0]       req_response,
   input  logic [nne_pkg::LCNT_W-1:0]       req_first_link,
   input  logic [nne_pkg::LCNT_W-1:0]       req_link_count,
   input  logic [7:0]                       req_link_index,
   input  logic [nne_pkg::SRC_W-1:0]        req_source_neuron,
   input  logic signed [nne_pkg::ACT_W-1:0] req_weight,
   input  logic signed [nne_pkg::ACT_W-1:0] req_value,
   input  logic                             req_last_input,
   input  logic                             req_snapshot,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [nne_pkg::OUT_W-1:0]        rsp_out_value,
   output logic [nne_pkg::ORD_W-1:0]        rsp_out_ordinal,
   output logic                             rsp_out_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [1:0]                       csr_index,
   input  logic [nne_pkg::CFG_W-1:0]        csr_wdata
);

   localparam int NA = nne_pkg::NEURON_AW;
   localparam int MULW = nne_pkg::X_W + nne_pkg::SIG_AW + 1;

   nne_pkg::state_type             state_ff, state_in;
   logic [nne_pkg::CFG_W-1:0]      flush_depth_ff, neuron_count_ff;
   logic [nne_pkg::MAX_NEURONS-1:0] valid_ff, valid_in;

   logic [1:0]                     cap_kind_ff, cap_kind_in;
   logic [NA-1:0]                  cap_ni_ff, cap_ni_in;
   logic [1:0]                     cap_type_ff, cap_type_in;
   logic [nne_pkg::RESP_W-1:0]     cap_resp_ff, cap_resp_in;
   logic [nne_pkg::LCNT_W-1:0]     cap_start_ff, cap_start_in;
   logic [nne_pkg::LCNT_W-1:0]     cap_len_ff, cap_len_in;
   logic signed [nne_pkg::ACT_W-1:0] cap_value_ff, cap_value_in;
   logic                           cap_last_ff, cap_last_in;
   logic                           cap_snap_ff, cap_snap_in;

   logic [nne_pkg::NCNT_W-1:0]     n_ff, n_in;
   logic [nne_pkg::CFG_W-1:0]      passes_ff, passes_in;
   logic [nne_pkg::CFG_W-1:0]      p_ff, p_in;
   logic                           final_ff, final_in;
   logic [nne_pkg::NCNT_W-1:0]     c_ff, c_in;
   nne_pkg::node_word_type         info_ff, info_in;
   logic [nne_pkg::LCNT_W-1:0]     k_ff, k_in;
   logic signed [nne_pkg::ACT_W-1:0] weight_ff, weight_in;
   logic                           act_vld_ff, act_vld_in;
   logic signed [nne_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [nne_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [nne_pkg::RCNT_W-1:0]     cnt_ff, cnt_in;

   logic                           pend_valid_ff, pend_valid_in;
   logic [nne_pkg::OUT_W-1:0]      pend_value_ff, pend_value_in;
   logic [nne_pkg::ORD_W-1:0]      pend_ord_ff, pend_ord_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [nne_pkg::OUT_W-1:0]      rsp_value_ff, rsp_value_in;
   logic [nne_pkg::ORD_W-1:0]      rsp_ord_ff, rsp_ord_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           node_wr_en;
   logic [NA-1:0]                  node_wr_addr, node_rd_addr;
   nne_pkg::node_word_type         node_wr_data, node_rd;
   logic                           link_wr_en;
   logic [nne_pkg::LINK_AW-1:0]    link_wr_addr, link_rd_addr;
   nne_pkg::link_word_type         link_wr_data, link_rd;
   logic [nne_pkg::LCNT_W:0]       link_sum;

   nne_pkg::div_req_type           div_req;
   nne_pkg::div_rsp_type           div_rsp;
   logic [nne_pkg::X_W-1:0]        sig_u;
   logic [MULW-1:0]                idx_wide;
   logic [nne_pkg::SIG_AW-1:0]     rom_addr;
   logic [nne_pkg::OUT_W-1:0]      rom_data;

   logic                           slot_free;
   logic                           emit;
   logic signed [nne_pkg::ACT_W-1:0] act_sel;
   logic [NA-1:0]                  src_idx;

   nne_ram #(
      .WIDTH ($bits(nne_pkg::node_word_type)),
      .DEPTH (nne_pkg::MAX_NEURONS)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (node_wr_addr),
      .wr_data (node_wr_data),
      .rd_addr (node_rd_addr),
      .rd_data (node_rd)
   );

   nne_ram #(
      .WIDTH ($bits(nne_pkg::link_word_type)),
      .DEPTH (nne_pkg::MAX_LINKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd)
   );

   nne_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   nne_sigmoid_rom u_sigmoid (
      .clock (clock),
      .addr  (rom_addr),
      .data  (rom_data)
   );

   assign req_stall       = (state_ff != nne_pkg::ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_out_ordinal = rsp_ord_ff;
   assign rsp_out_last    = rsp_last_ff;

   assign link_wr_addr        = req_link_index[nne_pkg::LINK_AW-1:0];
   assign link_wr_data.src    = req_source_neuron;
   assign link_wr_data.weight = req_weight;
   assign link_sum            = {1'b0, info_ff.start} + {1'b0, k_ff};
   assign link_rd_addr        = link_sum[nne_pkg::LINK_AW-1:0];
   assign src_idx             = link_rd.src[NA-1:0];

   // Table index from the saturated net input, offset by +8 to make it unsigned.
   always_comb begin
      sig_u    = {~div_rsp.x[nne_pkg::X_W-1], div_rsp.x[nne_pkg::X_W-2:0]};
      idx_wide = (MULW'(sig_u) * MULW'(nne_pkg::SIGMOID_ENTRIES)) >> nne_pkg::X_W;
      if (idx_wide >= MULW'(nne_pkg::SIGMOID_ENTRIES)) begin
         rom_addr = nne_pkg::SIG_AW'(nne_pkg::SIGMOID_ENTRIES - 1);
      end else begin
         rom_addr = idx_wide[nne_pkg::SIG_AW-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      cap_kind_in   = cap_kind_ff;
      cap_ni_in     = cap_ni_ff;
      cap_type_in   = cap_type_ff;
      cap_resp_in   = cap_resp_ff;
      cap_start_in  = cap_start_ff;
      cap_len_in    = cap_len_ff;
      cap_value_in  = cap_value_ff;
      cap_last_in   = cap_last_ff;
      cap_snap_in   = cap_snap_ff;
      n_in          = n_ff;
      passes_in     = passes_ff;
      p_in          = p_ff;
      final_in      = final_ff;
      c_in          = c_ff;
      info_in       = info_ff;
      k_in          = k_ff;
      weight_in     = weight_ff;
      act_vld_in    = act_vld_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      pend_ord_in   = pend_ord_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_ord_in    = rsp_ord_ff;
      rsp_last_in   = rsp_last_ff;

      node_wr_en   = 1'b0;
      node_wr_addr = c_ff[NA-1:0];
      node_wr_data = node_rd;
      node_rd_addr = c_ff[NA-1:0];
      link_wr_en   = 1'b0;

      div_req.start = 1'b0;
      div_req.neg   = acc_ff[nne_pkg::ACC_W-1];
      div_req.mag   = acc_ff[nne_pkg::ACC_W-1] ? nne_pkg::ACC_W'(-acc_ff)
                                               : nne_pkg::ACC_W'(acc_ff);
      div_req.resp  = info_ff.resp;

      act_sel   = act_vld_ff ? node_rd.act : '0;
      slot_free = !rsp_valid_ff || !rsp_stall;
      emit      = final_ff && (info_ff.ntype == nne_pkg::NTYPE_OUTPUT) &&
                  (cnt_ff < nne_pkg::RCNT_W'(nne_pkg::MAX_RESULTS));

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         nne_pkg::ST_IDLE: begin
            node_rd_addr = req_neuron_index[NA-1:0];
            cap_kind_in  = req_kind;
            cap_ni_in    = req_neuron_index[NA-1:0];
            cap_type_in  = req_neuron_type;
            cap_resp_in  = req_response;
            cap_start_in = req_first_link;
            cap_len_in   = req_link_count;
            cap_value_in = req_value;
            cap_last_in  = req_last_input;
            cap_snap_in  = req_snapshot;
            if (req_valid) begin
               if (req_kind == nne_pkg::KIND_LINK) begin
                  link_wr_en = 1'b1;
               end else if (req_kind == nne_pkg::KIND_NEURON ||
                            req_kind == nne_pkg::KIND_INPUT) begin
                  state_in = nne_pkg::ST_MERGE;
               end
            end
         end
         nne_pkg::ST_MERGE: begin
            // The neuron RAM word holds both the activation and the table entry.
            node_wr_en   = 1'b1;
            node_wr_addr = cap_ni_ff;
            if (cap_kind_ff == nne_pkg::KIND_NEURON) begin
               node_wr_data.ntype = cap_type_ff;
               node_wr_data.resp  = cap_resp_ff;
               node_wr_data.start = cap_start_ff;
               node_wr_data.len   = cap_len_ff;
               state_in = nne_pkg::ST_IDLE;
            end else begin
               node_wr_data.act    = cap_value_ff;
               valid_in[cap_ni_ff] = 1'b1;
               if (cap_last_ff) begin
                  n_in = (neuron_count_ff > nne_pkg::CFG_W'(nne_pkg::MAX_NEURONS)) ?
                         nne_pkg::NCNT_W'(nne_pkg::MAX_NEURONS) :
                         nne_pkg::NCNT_W'(neuron_count_ff);
                  passes_in = (cap_snap_ff && flush_depth_ff != '0) ? flush_depth_ff
                                                                    : nne_pkg::CFG_W'(1);
                  p_in     = '0;
                  state_in = nne_pkg::ST_PASS;
               end else begin
                  state_in = nne_pkg::ST_IDLE;
               end
            end
         end
         nne_pkg::ST_PASS: begin
            final_in = (p_ff + nne_pkg::CFG_W'(1) == passes_ff);
            cnt_in   = '0;
            c_in     = '0;
            state_in = nne_pkg::ST_SCAN;
         end
         nne_pkg::ST_SCAN: begin
            state_in = (c_ff >= n_ff) ? nne_pkg::ST_PASS_END : nne_pkg::ST_SCAN_CHK;
         end
         nne_pkg::ST_SCAN_CHK: begin
            c_in = c_ff + nne_pkg::NCNT_W'(1);
            if (node_rd.ntype == nne_pkg::NTYPE_INPUT) begin
               state_in = nne_pkg::ST_SCAN;
            end else begin
               // First neuron after the inputs is the bias, whatever its type.
               node_wr_en             = 1'b1;
               node_wr_data.act       = nne_pkg::ACT_W'(nne_pkg::ONE);
               valid_in[c_ff[NA-1:0]] = 1'b1;
               state_in               = nne_pkg::ST_NODE;
            end
         end
         nne_pkg::ST_NODE: begin
            state_in = (c_ff >= n_ff) ? nne_pkg::ST_PASS_END : nne_pkg::ST_INFO;
         end
         nne_pkg::ST_INFO: begin
            info_in  = node_rd;
            k_in     = '0;
            acc_in   = '0;
            state_in = nne_pkg::ST_LINK;
         end
         nne_pkg::ST_LINK: begin
            state_in = (k_ff == info_ff.len) ? nne_pkg::ST_DIV : nne_pkg::ST_SRC;
         end
         nne_pkg::ST_SRC: begin
            node_rd_addr = src_idx;
            act_vld_in   = valid_ff[src_idx];
            weight_in    = link_rd.weight;
            state_in     = nne_pkg::ST_MUL;
         end
         nne_pkg::ST_MUL: begin
            prod_in  = nne_pkg::PROD_W'(weight_ff * act_sel);
            state_in = nne_pkg::ST_ACC;
         end
         nne_pkg::ST_ACC: begin
            acc_in   = acc_ff + nne_pkg::ACC_W'(prod_ff);
            k_in     = k_ff + nne_pkg::LCNT_W'(1);
            state_in = nne_pkg::ST_LINK;
         end
         nne_pkg::ST_DIV: begin
            div_req.start = 1'b1;
            state_in      = nne_pkg::ST_DIVW;
         end
         nne_pkg::ST_DIVW: begin
            if (div_rsp.done) begin
               state_in = nne_pkg::ST_WB;
            end
         end
         nne_pkg::ST_WB: begin
            // The newest output waits in a pending slot until it is known whether it is last.
            if (!(emit && pend_valid_ff && !slot_free)) begin
               node_wr_en             = 1'b1;
               node_wr_data           = info_ff;
               node_wr_data.act       = nne_pkg::ACT_W'(rom_data);
               valid_in[c_ff[NA-1:0]] = 1'b1;
               c_in                   = c_ff + nne_pkg::NCNT_W'(1);
               if (emit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = pend_value_ff;
                     rsp_ord_in   = pend_ord_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_value_in = rom_data;
                  pend_ord_in   = cnt_ff[nne_pkg::ORD_W-1:0];
                  cnt_in        = cnt_ff + nne_pkg::RCNT_W'(1);
               end
               state_in = nne_pkg::ST_NODE;
            end
         end
         nne_pkg::ST_PASS_END: begin
            if (final_ff) begin
               state_in = nne_pkg::ST_FLUSH;
            end else begin
               p_in     = p_ff + nne_pkg::CFG_W'(1);
               state_in = nne_pkg::ST_PASS;
            end
         end
         nne_pkg::ST_FLUSH: begin
            if (!pend_valid_ff || slot_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = pend_value_ff;
                  rsp_ord_in    = pend_ord_ff;
                  rsp_last_in   = 1'b1;
                  pend_valid_in = 1'b0;
               end
               if (cap_snap_ff) begin
                  for (int i = 0; i < nne_pkg::MAX_NEURONS; i++) begin
                     if (i < n_ff) begin
                        valid_in[i] = 1'b0;
                     end
                  end
               end
               state_in = nne_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nne_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= nne_pkg::ST_IDLE;
         flush_depth_ff  <= nne_pkg::CFG_W'(1);
         neuron_count_ff <= '0;
         valid_ff        <= '0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               nne_pkg::CSR_FLUSH_DEPTH:  flush_depth_ff  <= csr_wdata;
               nne_pkg::CSR_NEURON_COUNT: neuron_count_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cap_kind_ff   <= cap_kind_in;
      cap_ni_ff     <= cap_ni_in;
      cap_type_ff   <= cap_type_in;
      cap_resp_ff   <= cap_resp_in;
      cap_start_ff  <= cap_start_in;
      cap_len_ff    <= cap_len_in;
      cap_value_ff  <= cap_value_in;
      cap_last_ff   <= cap_last_in;
      cap_snap_ff   <= cap_snap_in;
      n_ff          <= n_in;
      passes_ff     <= passes_in;
      p_ff          <= p_in;
      final_ff      <= final_in;
      c_ff          <= c_in;
      info_ff       <= info_in;
      k_ff          <= k_in;
      weight_ff     <= weight_in;
      act_vld_ff    <= act_vld_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      cnt_ff        <= cnt_in;
      pend_value_ff <= pend_value_in;
      pend_ord_ff   <= pend_ord_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_ord_ff    <= rsp_ord_in;
      rsp_last_ff   <= rsp_last_in;
   end

   a_pend_only_final: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> final_ff)
      else $error("pending output outside the final pass");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nne_pkg::ST_IDLE) |-> !pend_valid_ff)
      else $error("pending output left behind at end of evaluation");

   a_link_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_kind == nne_pkg::KIND_LINK)
      |=> (state_ff == nne_pkg::ST_IDLE))
      else $error("link load did not complete in one cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nne_pkg::ST_WB) |-> (cnt_ff <= nne_pkg::RCNT_W'(nne_pkg::MAX_RESULTS)))
      else $error("output count beyond limit");

endmodule

`default_nettype wire

/* tb/neat_network_evaluator_tb.sv */
// Self-checking testbench of the NEAT network evaluator with a built-in network predictor.
`default_nettype none

module neat_network_evaluator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_NONE    = 2'd3;
   localparam logic [1:0] NTYPE_BIAS   = 2'd1;
   localparam logic [1:0] NTYPE_HIDDEN = 2'd2;
   localparam longint     CYCLE_LIMIT  = 3000000;

   typedef struct {
      logic [1:0]         kind;
      logic [5:0]         idx;
      logic [1:0]         ntype;
      logic [14:0]        resp;
      logic [7:0]         first_link;
      logic [7:0]         link_count;
      logic [7:0]         link_idx;
      logic [5:0]         src;
      logic signed [15:0] weight;
      logic signed [15:0] value;
      logic               is_last;
      logic               snap;
   } net_item_type;

   typedef struct {
      logic [12:0] value;
      logic [5:0]  ordinal;
      logic        is_last;
   } net_output_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_kind = '0;
   logic [5:0] req_neuron_index = '0;
   logic [1:0] req_neuron_type = '0;
   logic [14:0] req_response = '0;
   logic [7:0] req_first_link = '0;
   logic [7:0] req_link_count = '0;
   logic [7:0] req_link_index = '0;
   logic [5:0] req_source_neuron = '0;
   logic signed [15:0] req_weight = '0;
   logic signed [15:0] req_value = '0;
   logic req_last_input = 1'b0;
   logic req_snapshot = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [12:0] rsp_out_value;
   logic [5:0] rsp_out_ordinal;
   logic rsp_out_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [6:0] csr_wdata = '0;

   neat_network_evaluator dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mirror of the network tables and configuration.
   logic [6:0]         flush_cfg = 7'd1;
   logic [6:0]         count_cfg = 7'd0;
   logic signed [15:0] act_m [64];
   logic [1:0]         ntype_m [64];
   logic [14:0]        resp_m [64];
   logic [7:0]         start_m [64];
   logic [7:0]         len_m [64];
   logic [5:0]         src_m [256];
   logic signed [15:0] weight_m [256];
   logic [12:0]        sigmoid_lut [1024];

   net_output_type pending_outputs[$];
   int     err_count = 0;
   int     items_sent = 0;
   int     outputs_seen = 0;
   int     evals_run = 0;
   longint cycles = 0;
   longint recent_busy = 0;
   int     idle_pct = 0;
   int     stall_pct = 0;

   function automatic longint unsigned exp_q31(longint unsigned t);
      longint unsigned u, u2, u3, u4, e;
      u  = (t << (31 - nne_pkg::FRAC_BITS)) >> 8;
      u2 = (u * u) >> 31;
      u3 = (u2 * u) >> 31;
      u4 = (u2 * u2) >> 31;
      e  = (64'd1 << 31) - u + u2 / 2 - u3 / 6 + u4 / 24;
      for (int i = 0; i < 8; i++) begin
         e = (e * e + (64'd1 << 30)) >> 31;
      end
      return e;
   endfunction

   function automatic longint unsigned logistic_q12(longint unsigned t);
      longint unsigned d;
      d = (64'd1 << 31) + exp_q31(t);
      return ((64'd4096 << 31) + d / 2) / d;
   endfunction

   function automatic logic [12:0] neuron_activation(int c);
      longint acc, mag, x, r, idx;
      int l;
      acc = 0;
      for (int k = 0; k < len_m[c]; k++) begin
         l = (start_m[c] + k) % 256;
         acc += longint'(weight_m[l]) * longint'(act_m[src_m[l]]);
      end
      r = (resp_m[c] == 0) ? 1 : longint'(resp_m[c]);
      mag = ((acc < 0) ? -acc : acc) / r;
      if (mag > 32768) mag = 32768;
      x = (acc < 0) ? -mag : mag;
      if (x > 32767) x = 32767;
      idx = ((x + 32768) * 1024) >> 16;
      if (idx > 1023) idx = 1023;
      return sigmoid_lut[idx];
   endfunction

   task automatic evaluate_network(logic snap);
      int n, passes, c;
      logic [12:0] a;
      net_output_type emitted[$];
      net_output_type o;
      n = (count_cfg > 64) ? 64 : count_cfg;
      passes = snap ? ((flush_cfg != 0) ? flush_cfg : 1) : 1;
      recent_busy = 64;
      evals_run++;
      for (int p = 0; p < passes; p++) begin
         recent_busy += 2 * n;
         c = 0;
         while (c < n && ntype_m[c] == nne_pkg::NTYPE_INPUT) c++;
         if (c >= n) continue;
         act_m[c] = 16'sd4096;
         c++;
         for (; c < n; c++) begin
            a = neuron_activation(c);
            act_m[c] = $signed({3'b000, a});
            recent_busy += 4 * len_m[c] + 22;
            if (p == passes - 1 && ntype_m[c] == nne_pkg::NTYPE_OUTPUT &&
                emitted.size() < 64) begin
               o.value = a;
               o.ordinal = 6'(emitted.size());
               o.is_last = 1'b0;
               emitted = {emitted, o};
            end
         end
      end
      if (emitted.size() > 0) emitted[$].is_last = 1'b1;
      foreach (emitted[i]) pending_outputs = {pending_outputs, emitted[i]};
      if (snap) begin
         for (int i = 0; i < n; i++) act_m[i] = '0;
      end
   endtask

   task automatic predict_request(net_item_type it);
      case (it.kind)
         nne_pkg::KIND_NEURON: begin
            ntype_m[it.idx] = it.ntype;
            resp_m[it.idx] = it.resp;
            start_m[it.idx] = it.first_link;
            len_m[it.idx] = it.link_count;
         end
         nne_pkg::KIND_LINK: begin
            src_m[it.link_idx] = it.src;
            weight_m[it.link_idx] = it.weight;
         end
         nne_pkg::KIND_INPUT: begin
            act_m[it.idx] = it.value;
            if (it.is_last) evaluate_network(it.snap);
         end
         default: ;
      endcase
   endtask

   function automatic net_item_type random_item();
      net_item_type it;
      it.kind = 2'($urandom);
      it.idx = 6'($urandom);
      it.ntype = 2'($urandom);
      it.resp = 15'($urandom);
      it.first_link = 8'($urandom);
      it.link_count = 8'($urandom);
      it.link_idx = 8'($urandom);
      it.src = 6'($urandom);
      it.weight = 16'($urandom);
      it.value = 16'($urandom);
      it.is_last = 1'($urandom);
      it.snap = 1'($urandom);
      return it;
   endfunction

   task automatic send_item(net_item_type it);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= it.kind;
      req_neuron_index <= it.idx;
      req_neuron_type <= it.ntype;
      req_response <= it.resp;
      req_first_link <= it.first_link;
      req_link_count <= it.link_count;
      req_link_index <= it.link_idx;
      req_source_neuron <= it.src;
      req_weight <= it.weight;
      req_value <= it.value;
      req_last_input <= it.is_last;
      req_snapshot <= it.snap;
      do @(posedge clock); while (req_stall);
      items_sent++;
      predict_request(it);
   endtask

   task automatic load_neuron(int idx, logic [1:0] nt, logic [14:0] resp,
                              logic [7:0] first_link, logic [7:0] link_count);
      net_item_type it;
      it = random_item();
      it.kind = nne_pkg::KIND_NEURON;
      it.idx = 6'(idx);
      it.ntype = nt;
      it.resp = resp;
      it.first_link = first_link;
      it.link_count = link_count;
      send_item(it);
   endtask

   task automatic load_link(int idx, logic [5:0] src, logic signed [15:0] weight);
      net_item_type it;
      it = random_item();
      it.kind = nne_pkg::KIND_LINK;
      it.link_idx = 8'(idx);
      it.src = src;
      it.weight = weight;
      send_item(it);
   endtask

   task automatic present_value(int idx, logic signed [15:0] value, logic is_last, logic snap);
      net_item_type it;
      it = random_item();
      it.kind = nne_pkg::KIND_INPUT;
      it.idx = 6'(idx);
      it.value = value;
      it.is_last = is_last;
      it.snap = snap;
      send_item(it);
   endtask

   // Waits for all outputs and then for the tail of an evaluation that emits nothing.
   task automatic drain_outputs();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_outputs.size() > 0) @(posedge clock);
      repeat (recent_busy + 50) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [6:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == nne_pkg::CSR_FLUSH_DEPTH) flush_cfg = data;
      else if (idx == nne_pkg::CSR_NEURON_COUNT) count_cfg = data;
      @(posedge clock);
   endtask

   task automatic configure(logic [6:0] flush, logic [6:0] count);
      drain_outputs();
      write_csr(nne_pkg::CSR_FLUSH_DEPTH, flush);
      write_csr(nne_pkg::CSR_NEURON_COUNT, count);
   endtask

   // Every neuron entry gets written once so no evaluation reads an unwritten entry.
   // Link entries are only referenced once they have been written.
   task automatic test_table_fill();
      for (int i = 0; i < 64; i++)
         load_neuron(i, (i == 0) ? nne_pkg::NTYPE_INPUT : nne_pkg::NTYPE_OUTPUT,
                     15'(4096 + i), 8'(4 * i), 8'd0);
   endtask

   task automatic test_directed();
      configure(7'd1, 7'd4);
      load_neuron(0, nne_pkg::NTYPE_INPUT, 15'd4096, 8'd0, 8'd0);
      load_neuron(1, NTYPE_BIAS, 15'd4096, 8'd0, 8'd0);
      // Link range runs past the end of the link table and wraps.
      load_neuron(2, nne_pkg::NTYPE_OUTPUT, 15'd32767, 8'd254, 8'd3);
      load_neuron(3, nne_pkg::NTYPE_OUTPUT, 15'd0, 8'd10, 8'd2);
      load_link(254, 6'd0, -16'sd32768);
      load_link(255, 6'd1, 16'sd32767);
      load_link(0, 6'd0, 16'sd32767);
      load_link(10, 6'd0, 16'sd1);
      load_link(11, 6'd2, -16'sd4096);
      present_value(0, -16'sd32768, 1'b1, 1'b1);
      present_value(0, 16'sd32767, 1'b1, 1'b0);
      present_value(0, 16'sd100, 1'b0, 1'b0);
      begin
         net_item_type it;
         it = random_item();
         it.kind = KIND_NONE;
         send_item(it);
      end
      present_value(0, 16'sd5, 1'b1, 1'b0);
      // The neuron after the inputs is the bias even when typed as hidden.
      load_neuron(1, NTYPE_HIDDEN, 15'd4096, 8'd0, 8'd0);
      load_neuron(3, nne_pkg::NTYPE_OUTPUT, 15'd4096, 8'd254, 8'd3);
      present_value(0, 16'sd2048, 1'b1, 1'b1);
      load_neuron(3, nne_pkg::NTYPE_OUTPUT, 15'd0, 8'd10, 8'd2);
      configure(7'd0, 7'd127);
      present_value(0, 16'sd4096, 1'b1, 1'b1);
      configure(7'd64, 7'd4);
      present_value(0, -16'sd4096, 1'b1, 1'b1);
      configure(7'd1, 7'd1);
      present_value(0, 16'sd7, 1'b1, 1'b1);
      configure(7'd1, 7'd2);
      present_value(0, 16'sd7, 1'b1, 1'b0);
      configure(7'd3, 7'd64);
      present_value(0, 16'sd300, 1'b1, 1'b0);
   endtask

   task automatic build_random_net(int n);
      int ni;
      logic [1:0] nt;
      logic [7:0] fl, lc;
      ni = ($urandom_range(19) == 0) ? n : $urandom_range(0, 3);
      for (int c = 0; c < n; c++) begin
         if (c < ni) nt = nne_pkg::NTYPE_INPUT;
         else if (c == ni) nt = 2'($urandom_range(1, 3));
         else nt = ($urandom_range(9) == 0) ? 2'($urandom) : 2'($urandom_range(2, 3));
         fl = 8'($urandom);
         lc = 8'($urandom_range(0, 4));
         load_neuron(c, nt,
                     ($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(1, 8192)),
                     fl, lc);
         for (int k = 0; k < lc; k++)
            load_link(fl + k,
                      ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(0, n - 1)),
                      16'($urandom));
      end
      repeat ($urandom_range(1, 3)) begin
         if (ni == 0) begin
            present_value(0, 16'($urandom), 1'b1, 1'($urandom));
         end else begin
            for (int j = 0; j < ni; j++)
               present_value(j, ($urandom_range(3) == 0) ? 16'($urandom)
                             : 16'($signed($urandom_range(0, 16384)) - 8192),
                             j == ni - 1, 1'($urandom));
         end
      end
   endtask

   task automatic test_random_phase(int idle, int stall, int quota);
      int start_items;
      configure(7'($urandom_range(1, 4)), 7'($urandom_range(4, 16)));
      idle_pct = idle;
      stall_pct = stall;
      start_items = items_sent;
      while (items_sent - start_items < quota) begin
         if ($urandom_range(9) == 0) begin
            net_item_type it;
            it = random_item();
            if (it.kind == nne_pkg::KIND_INPUT) it.is_last = 1'b0;
            // A stray neuron entry keeps no links, so it never points at unwritten ones.
            if (it.kind == nne_pkg::KIND_NEURON) it.link_count = 8'd0;
            send_item(it);
         end else begin
            build_random_net(count_cfg);
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      net_output_type exp_out;
      if (!reset && rsp_valid && !rsp_stall) begin
         outputs_seen++;
         if (pending_outputs.size() == 0) begin
            $error("unexpected output transaction: value %0d ordinal %0d",
                   rsp_out_value, rsp_out_ordinal);
            err_count++;
         end else begin
            exp_out = pending_outputs.pop_front();
            if (rsp_out_value !== exp_out.value) begin
               $error("out_value: expected %0d, got %0d", exp_out.value, rsp_out_value);
               err_count++;
            end
            if (rsp_out_ordinal !== exp_out.ordinal) begin
               $error("out_ordinal: expected %0d, got %0d", exp_out.ordinal, rsp_out_ordinal);
               err_count++;
            end
            if (rsp_out_last !== exp_out.is_last) begin
               $error("out_last: expected %0d, got %0d", exp_out.is_last, rsp_out_last);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      longint x;
      for (int k = 0; k < 1024; k++) begin
         x = ((2 * longint'(k) + 1) * 65536) / 2048 - 32768;
         if (x >= 0) sigmoid_lut[k] = 13'(logistic_q12(x));
         else sigmoid_lut[k] = 13'(4096 - logistic_q12(-x));
      end
      foreach (act_m[i]) act_m[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_fill();
      test_directed();
      test_random_phase(0, 0, 50);
      test_random_phase(78, 0, 50);
      test_random_phase(0, 78, 50);
      test_random_phase(12, 12, 50);
      drain_outputs();
      if (pending_outputs.size() > 0) begin
         $error("%0d expected outputs never arrived", pending_outputs.size());
         err_count++;
      end
      $display("Sent %0d requests, ran %0d network evaluations, checked %0d outputs.",
               items_sent, evals_run, outputs_seen);
      $display("Covered wrapped link ranges, bias handling, flush depths 0 to 64 %s",
               "and four handshake mixes.");
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* neat_network_evaluator.f */
hdl/nne_pkg.sv
hdl/nne_ram.sv
hdl/nne_sigmoid_rom.sv
hdl/nne_divider.sv
hdl/neat_network_evaluator.sv
tb/neat_network_evaluator_tb.sv
